### design/lrfp_pkg.sv
// ----------------------------------------------------------------------------
// lrfp_pkg
// Types, codes and helper functions shared by the realtime LED frame parser.
// ----------------------------------------------------------------------------
`default_nettype none

package lrfp_pkg;

  // Largest packet that is parsed; longer ones are consumed and rejected.
  localparam int MAX_PACKET_BYTES = 2048;
  localparam logic [17:0] DEFAULT_BLANK_MS = 18'd1000;
  localparam logic [7:0] TIMEOUT_NEVER = 8'd255;

  // Result queue geometry.
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int LEVEL_W = $clog2(FIFO_DEPTH + 1);

  // Configuration register indexes.
  localparam logic CFG_LED_COUNT = 1'b0;
  localparam logic CFG_SEQ_MODE = 1'b1;

  // Protocol codes carried in byte 0.
  localparam logic [2:0] PROTO_NOTIFY = 3'd0;
  localparam logic [2:0] PROTO_INDEXED = 3'd1;
  localparam logic [2:0] PROTO_SEQ_RGB = 3'd2;
  localparam logic [2:0] PROTO_SEQ_RGBW = 3'd3;
  localparam logic [2:0] PROTO_OFFSET = 3'd4;
  localparam logic [2:0] PROTO_CLAMP = 3'd7;

  typedef enum logic [1:0] {
    RES_PIXEL  = 2'd0,
    RES_SHOW   = 2'd1,
    RES_REJECT = 2'd2,
    RES_BLANK  = 2'd3
  } res_type_t;

  typedef struct packed {
    res_type_t   rtype;
    logic [15:0] led_index;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  white;
    logic        last;
  } result_t;

  // Results produced by one accepted item, oldest in r0.
  typedef struct packed {
    logic [1:0] count;
    result_t    r0;
    result_t    r1;
  } push_t;

  // Remainder by three of a 12-bit value: base-4 digits sum to the same residue.
  function automatic logic [1:0] mod3_12(input logic [11:0] v);
    logic [4:0] s1;
    logic [2:0] s2;
    logic [2:0] s3;
    s1 = 5'(v[1:0]) + 5'(v[3:2]) + 5'(v[5:4]) + 5'(v[7:6]) + 5'(v[9:8]) + 5'(v[11:10]);
    s2 = 3'(s1[1:0]) + 3'(s1[3:2]) + 3'(s1[4]);
    s3 = 3'(s2[1:0]) + 3'(s2[2]);
    if (s3 >= 3'd3) begin
      s3 = s3 - 3'd3;
    end
    return s3[1:0];
  endfunction

  function automatic logic length_ok(input logic [2:0] code, input logic [11:0] len);
    logic [11:0] s;
    logic        ok;
    s = len - 12'd2;
    ok = 1'b0;
    if (len >= 12'd2 && {1'b0, len} <= 13'(MAX_PACKET_BYTES)) begin
      case (code)
        PROTO_NOTIFY:   ok = (s == 12'd0);
        PROTO_INDEXED:  ok = (s[1:0] == 2'd0);
        PROTO_SEQ_RGB:  ok = (mod3_12(s) == 2'd0);
        PROTO_SEQ_RGBW: ok = (s[1:0] == 2'd0);
        // At least the two index bytes, then whole RGB triples.
        PROTO_OFFSET:   ok = (mod3_12(s) == 2'd2);
        default:        ok = 1'b0;
      endcase
    end
    return ok;
  endfunction

endpackage

`default_nettype wire

### design/lrfp_parser.sv
// ----------------------------------------------------------------------------
// lrfp_parser
// Frame state, configuration registers and the single-pass decode of one item.
// ----------------------------------------------------------------------------
`default_nettype none

module lrfp_parser import lrfp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        accept,
  input  wire logic        kind,
  input  wire logic [7:0]  data_byte,
  input  wire logic [11:0] packet_length,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data,
  output push_t            push
);

  logic [15:0] led_count;
  logic        seq_mode;

  logic [11:0] byte_position, byte_position_next;
  logic [11:0] frame_length, frame_length_next;
  logic [2:0]  protocol_code, protocol_code_next;
  logic [7:0]  timeout_code, timeout_code_next;
  logic        frame_good, frame_good_next;
  logic [15:0] pixel_index, pixel_index_next;
  logic [1:0]  channel_phase, channel_phase_next;
  logic [23:0] staged_channels, staged_channels_next;
  logic [17:0] blank_countdown, blank_countdown_next;
  logic        blank_disabled, blank_disabled_next;

  logic        pix_valid;
  result_t     pix;
  logic        fin_valid;
  result_t     fin;
  logic        blank_valid;
  logic [11:0] len;
  logic [2:0]  code;
  logic [11:0] pos_inc;
  logic        group_last;
  logic        wide_group;

  always_comb begin
    byte_position_next   = byte_position;
    frame_length_next    = frame_length;
    protocol_code_next   = protocol_code;
    timeout_code_next    = timeout_code;
    frame_good_next      = frame_good;
    pixel_index_next     = pixel_index;
    channel_phase_next   = channel_phase;
    staged_channels_next = staged_channels;
    blank_countdown_next = blank_countdown;
    blank_disabled_next  = blank_disabled;
    pix_valid   = 1'b0;
    pix         = '0;
    fin_valid   = 1'b0;
    fin         = '0;
    blank_valid = 1'b0;
    len         = (packet_length == 12'd0) ? 12'd1 : packet_length;
    code        = (data_byte > 8'd7) ? PROTO_CLAMP : data_byte[2:0];
    pos_inc     = byte_position + 12'd1;
    wide_group  = (protocol_code == PROTO_INDEXED) || (protocol_code == PROTO_SEQ_RGBW);
    group_last  = wide_group ? (channel_phase == 2'd3) : (channel_phase == 2'd2);

    if (kind) begin
      if (!blank_disabled) begin
        if (blank_countdown == 18'd0) begin
          blank_valid          = 1'b1;
          blank_countdown_next = DEFAULT_BLANK_MS;
        end else begin
          blank_countdown_next = blank_countdown - 18'd1;
        end
      end
    end else begin
      if (byte_position == 12'd0) begin
        if (code == PROTO_NOTIFY && seq_mode) begin
          code = PROTO_SEQ_RGB;
        end
        frame_length_next    = len;
        protocol_code_next   = code;
        frame_good_next      = length_ok(code, len);
        pixel_index_next     = '0;
        channel_phase_next   = '0;
        staged_channels_next = '0;
      end else if (byte_position == 12'd1) begin
        timeout_code_next = data_byte;
      end else if (frame_good) begin
        if (protocol_code == PROTO_OFFSET && byte_position == 12'd2) begin
          pixel_index_next = {data_byte, 8'd0};
        end else if (protocol_code == PROTO_OFFSET && byte_position == 12'd3) begin
          pixel_index_next = {pixel_index[15:8], data_byte};
        end else if (!group_last) begin
          staged_channels_next = {staged_channels[15:0], data_byte};
          channel_phase_next   = channel_phase + 2'd1;
        end else begin
          channel_phase_next   = '0;
          staged_channels_next = '0;
          pix.rtype = RES_PIXEL;
          if (protocol_code == PROTO_INDEXED) begin
            pix.led_index = {8'd0, staged_channels[23:16]};
            pix.red       = staged_channels[15:8];
            pix.green     = staged_channels[7:0];
            pix.blue      = data_byte;
          end else if (protocol_code == PROTO_SEQ_RGBW) begin
            pix.led_index    = pixel_index;
            pix.red          = staged_channels[23:16];
            pix.green        = staged_channels[15:8];
            pix.blue         = staged_channels[7:0];
            pix.white        = data_byte;
            pixel_index_next = pixel_index + 16'd1;
          end else begin
            pix.led_index    = pixel_index;
            pix.red          = staged_channels[15:8];
            pix.green        = staged_channels[7:0];
            pix.blue         = data_byte;
            pixel_index_next = pixel_index + 16'd1;
          end
          pix_valid = (pix.led_index < led_count);
        end
      end

      if (pos_inc >= frame_length_next) begin
        fin_valid = 1'b1;
        fin.rtype = frame_good_next ? RES_SHOW : RES_REJECT;
        fin.last  = 1'b1;
        if (frame_good_next) begin
          if (timeout_code_next == TIMEOUT_NEVER) begin
            blank_disabled_next = 1'b1;
          end else begin
            blank_disabled_next  = 1'b0;
            blank_countdown_next = (timeout_code_next == 8'd0) ? DEFAULT_BLANK_MS
                                 : {10'd0, timeout_code_next} * DEFAULT_BLANK_MS;
          end
        end
        byte_position_next = '0;
      end else begin
        byte_position_next = pos_inc;
      end
    end

    push = '0;
    if (blank_valid) begin
      push.count    = 2'd1;
      push.r0.rtype = RES_BLANK;
      push.r0.last  = 1'b1;
    end else if (pix_valid && fin_valid) begin
      push.count = 2'd2;
      push.r0    = pix;
      push.r1    = fin;
    end else if (pix_valid) begin
      push.count   = 2'd1;
      push.r0      = pix;
      push.r0.last = 1'b1;
    end else if (fin_valid) begin
      push.count = 2'd1;
      push.r0    = fin;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      led_count       <= '0;
      seq_mode        <= 1'b0;
      byte_position   <= '0;
      frame_length    <= '0;
      protocol_code   <= '0;
      timeout_code    <= '0;
      frame_good      <= 1'b0;
      pixel_index     <= '0;
      channel_phase   <= '0;
      staged_channels <= '0;
      blank_countdown <= '0;
      blank_disabled  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_LED_COUNT: led_count <= cfg_data;
          CFG_SEQ_MODE:  seq_mode <= cfg_data[0];
          default:       led_count <= led_count;
        endcase
      end
      if (accept) begin
        byte_position   <= byte_position_next;
        frame_length    <= frame_length_next;
        protocol_code   <= protocol_code_next;
        timeout_code    <= timeout_code_next;
        frame_good      <= frame_good_next;
        pixel_index     <= pixel_index_next;
        channel_phase   <= channel_phase_next;
        staged_channels <= staged_channels_next;
        blank_countdown <= blank_countdown_next;
        blank_disabled  <= blank_disabled_next;
      end
    end
  end

endmodule

`default_nettype wire

### design/lrfp_result_fifo.sv
// ----------------------------------------------------------------------------
// lrfp_result_fifo
// Small result queue: takes up to two results a cycle, hands out one.
// ----------------------------------------------------------------------------
`default_nettype none

module lrfp_result_fifo import lrfp_pkg::*; (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          wr_en,
  input  wire push_t         push,
  input  wire logic          rd_en,
  output result_t            head,
  output logic [LEVEL_W-1:0] level
);

  result_t            mem [FIFO_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [LEVEL_W-1:0] add_n;
  logic [LEVEL_W-1:0] sub_n;

  assign add_n = wr_en ? LEVEL_W'(push.count) : '0;
  assign sub_n = rd_en ? LEVEL_W'(1) : '0;
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en && push.count != 2'd0) begin
      mem[wr_ptr] <= push.r0;
    end
    if (wr_en && push.count == 2'd2) begin
      mem[wr_ptr + PTR_W'(1)] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(add_n);
      rd_ptr <= rd_ptr + PTR_W'(sub_n);
      level  <= level + add_n - sub_n;
    end
  end

endmodule

`default_nettype wire

### design/led_realtime_frame_parser.sv
// ----------------------------------------------------------------------------
// led_realtime_frame_parser
// Realtime LED frame parser with a blank-on-timeout countdown.
// ----------------------------------------------------------------------------
// Usage:
// The slave stream carries one item per transfer: tuser 0 is a packet byte,
// tuser 1 a one-millisecond tick. The packet length rides with byte 0 of each
// packet. The master stream carries results: pixel writes, frame shown, frame
// rejected, and blank all; tlast marks the final result caused by one item.
// Users must write the LED count and mode bit over the configuration port
// only while idle; the block does not enforce it. Each accepted item is
// decoded in the cycle it is accepted, against the frame state registers,
// and its results, up to two, are written to a four-entry result queue.
// Input takes one item per cycle while the queue has room for two results;
// the output drains one result per cycle while the receiver is ready, so an
// item that ends a frame with a pixel write adds two results to the queue.
// When the receiver stalls, the queue fills and tready drops until it drains.
// Reset (synchronous, active high) clears the queue, the frame state and both
// configuration registers; tready and tvalid stay low during reset.
// ----------------------------------------------------------------------------
`default_nettype none

module led_realtime_frame_parser import lrfp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,  // data_byte[7:0], packet_length[19:8]
  input  wire logic [0:0]  s_axis_tuser,  // kind[0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [47:0]      m_axis_tdata,  // led_index, red, green, blue, white
  output logic [1:0]       m_axis_tuser,  // result_type[1:0]
  output logic             m_axis_tlast,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data
);

  push_t              push;
  result_t            head;
  logic [LEVEL_W-1:0] level;
  logic               in_accept;
  logic               out_accept;

  assign s_axis_tready = !rst && (level <= LEVEL_W'(FIFO_DEPTH - 2));
  assign m_axis_tvalid = !rst && (level != '0);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign out_accept    = m_axis_tvalid && m_axis_tready;

  lrfp_parser u_parser (
    .clk           (clk),
    .rst           (rst),
    .accept        (in_accept),
    .kind          (s_axis_tuser[0]),
    .data_byte     (s_axis_tdata[7:0]),
    .packet_length (s_axis_tdata[19:8]),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .push          (push)
  );

  lrfp_result_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .wr_en (in_accept),
    .push  (push),
    .rd_en (out_accept),
    .head  (head),
    .level (level)
  );

  assign m_axis_tdata = {head.white, head.blue, head.green, head.red, head.led_index};
  assign m_axis_tuser = head.rtype;
  assign m_axis_tlast = head.last;

`ifndef SYNTHESIS
  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    level <= LEVEL_W'(FIFO_DEPTH))
    else $error("result queue overfilled");

  a_level_hold: assert property (@(posedge clk) disable iff (rst)
    !in_accept && !out_accept |=> level == $past(level))
    else $error("result queue level moved without a transfer");

  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    in_accept && push.count == 2'd2 |->
      push.r0.rtype == RES_PIXEL && !push.r0.last && push.r1.last)
    else $error("two results from one item are not pixel write then frame end");
`endif

endmodule

`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Realtime LED frame parser testbench
// Drives packet bytes and millisecond ticks into the slave stream, predicts
// every pixel write, show, reject and blank-all result in a cycle-free model
// of the parser, and checks the master stream against it in order. A short
// directed table covers the extremes and the corner cases of the frame rules.
// Random phases under several register settings, with bursty input and
// stalling output, follow it.
// ----------------------------------------------------------------------------

module testbench;
  import lrfp_pkg::*;

  localparam bit KIND_BYTE = 1'b0;
  localparam bit KIND_TICK = 1'b1;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 16;
  localparam int ITEMS_PER_PHASE = 75;
  localparam int N_PHASES = 8;
  localparam int N_ROWS = 30;

  typedef enum logic [1:0] {
    ROW_BYTE,
    ROW_TICK,
    ROW_LED_COUNT,
    ROW_SEQ_MODE
  } row_op_t;

  typedef struct packed {
    row_op_t     op;
    logic [7:0]  value;
    logic [11:0] len;
    logic [15:0] cfg_val;
    logic        typed;
    res_type_t   want;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;   // data_byte[7:0], packet_length[19:8]
  logic [0:0]  s_axis_tuser = '0;   // kind[0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;        // led_index, red, green, blue, white
  logic [1:0]  m_axis_tuser;        // result_type[1:0]
  logic        m_axis_tlast;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [15:0] cfg_data = '0;

  led_realtime_frame_parser dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Parser model state and register copies.
  logic [15:0] shadow_led_count = '0;
  logic        shadow_hyper = 1'b0;
  int unsigned byte_pos = 0;
  logic [11:0] frame_len = '0;
  logic [2:0]  frame_proto = '0;
  logic [7:0]  frame_timeout = '0;
  bit          frame_ok = 1'b0;
  logic [15:0] pix_index = '0;
  logic [1:0]  chan_phase = '0;
  logic [23:0] staged = '0;
  logic [17:0] countdown = '0;
  bit          blank_off = 1'b0;

  result_t step_results[$];
  result_t awaited_results[$];

  int fail_count = 0;
  int quiet_cycles = 0;
  int burst_left = 0;
  int items_sent = 0;
  int hold_requests = 0;
  bit no_gaps = 1'b0;

  dir_row_t dir_rows [N_ROWS] = '{
    '{ROW_TICK, 8'h00, 12'd0, 16'd0, 1'b1, RES_BLANK},      // countdown starts expired
    '{ROW_BYTE, 8'h00, 12'd1, 16'd0, 1'b1, RES_REJECT},     // short frame
    '{ROW_BYTE, 8'h02, 12'd0, 16'd0, 1'b1, RES_REJECT},     // zero length
    '{ROW_BYTE, 8'hFF, 12'd2, 16'd0, 1'b0, RES_PIXEL},      // unknown protocol
    '{ROW_BYTE, 8'h00, 12'hFFF, 16'd0, 1'b1, RES_REJECT},
    '{ROW_BYTE, 8'h00, 12'd2, 16'd0, 1'b0, RES_PIXEL},      // empty notifier
    '{ROW_BYTE, 8'hFF, 12'd0, 16'd0, 1'b1, RES_SHOW},       // blanking disabled
    '{ROW_TICK, 8'hFF, 12'hFFF, 16'd0, 1'b0, RES_PIXEL},
    '{ROW_LED_COUNT, 8'h00, 12'd0, 16'hFFFF, 1'b0, RES_PIXEL},
    '{ROW_SEQ_MODE, 8'h00, 12'd0, 16'd1, 1'b0, RES_PIXEL},
    '{ROW_BYTE, 8'h00, 12'd2, 16'd0, 1'b0, RES_PIXEL},
    '{ROW_TICK, 8'h00, 12'd0, 16'd0, 1'b0, RES_PIXEL},      // tick inside a packet
    '{ROW_BYTE, 8'h01, 12'd0, 16'd0, 1'b1, RES_SHOW},
    '{ROW_SEQ_MODE, 8'h00, 12'd0, 16'd0, 1'b0, RES_PIXEL},
    '{ROW_BYTE, 8'h01, 12'd6, 16'd0, 1'b0, RES_PIXEL},      // indexed RGB
    '{ROW_BYTE, 8'h00, 12'd0, 16'd0, 1'b0, RES_PIXEL},
    '{ROW_BYTE, 8'hFE, 12'd0, 16'd0, 1'b0, RES_PIXEL},
    '{ROW_BYTE, 8'h12, 12'd0, 16'd0, 1'b0, RES_PIXEL},
    '{ROW_BYTE, 8'h34, 12'd0, 16'd0, 1'b0, RES_PIXEL},
    '{ROW_BYTE, 8'h56, 12'd0, 16'd0, 1'b0, RES_PIXEL},
    '{ROW_BYTE, 8'h04, 12'd10, 16'd0, 1'b0, RES_PIXEL},     // offset RGB, index wraps
    '{ROW_BYTE, 8'h00, 12'd0, 16'd0, 1'b0, RES_PIXEL},
    '{ROW_BYTE, 8'hFF, 12'd0, 16'd0, 1'b0, RES_PIXEL},
    '{ROW_BYTE, 8'hFF, 12'd0, 16'd0, 1'b0, RES_PIXEL},
    '{ROW_BYTE, 8'h11, 12'd0, 16'd0, 1'b0, RES_PIXEL},
    '{ROW_BYTE, 8'h22, 12'd0, 16'd0, 1'b0, RES_PIXEL},
    '{ROW_BYTE, 8'h33, 12'd0, 16'd0, 1'b0, RES_PIXEL},
    '{ROW_BYTE, 8'h44, 12'd0, 16'd0, 1'b0, RES_PIXEL},
    '{ROW_BYTE, 8'h55, 12'd0, 16'd0, 1'b0, RES_PIXEL},
    '{ROW_BYTE, 8'h66, 12'd0, 16'd0, 1'b0, RES_PIXEL}
  };

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= 50) begin
      $display("%0t: mismatch: %s", $time, msg);
    end
  endtask

  task automatic add_result(input res_type_t kind_res, input logic [15:0] idx,
                            input logic [7:0] r, input logic [7:0] g,
                            input logic [7:0] b, input logic [7:0] w);
    result_t res;
    res.rtype = kind_res;
    res.led_index = idx;
    res.red = r;
    res.green = g;
    res.blue = b;
    res.white = w;
    res.last = 1'b0;
    step_results.push_back(res);
  endtask

  task automatic write_pixel(input logic [15:0] idx, input logic [7:0] r,
                             input logic [7:0] g, input logic [7:0] b,
                             input logic [7:0] w);
    if (idx < shadow_led_count) begin
      add_result(RES_PIXEL, idx, r, g, b, w);
    end
  endtask

  // Works out the results of one item and advances the frame state.
  task automatic decode_item(input bit kind, input logic [7:0] value,
                             input logic [11:0] len_in);
    logic [11:0] len;
    logic [2:0]  code;
    logic [23:0] st;
    int          s;
    int          p;
    int          group;
    step_results.delete();
    if (kind == KIND_TICK) begin
      if (!blank_off) begin
        if (countdown == 18'd0) begin
          add_result(RES_BLANK, 16'd0, 8'd0, 8'd0, 8'd0, 8'd0);
          countdown = DEFAULT_BLANK_MS;
        end else begin
          countdown = countdown - 18'd1;
        end
      end
    end else begin
      if (byte_pos == 0) begin
        len = (len_in == 12'd0) ? 12'd1 : len_in;
        code = (value > 8'd7) ? PROTO_CLAMP : value[2:0];
        if (code == PROTO_NOTIFY && shadow_hyper) begin
          code = PROTO_SEQ_RGB;
        end
        frame_len = len;
        frame_proto = code;
        frame_ok = 1'b0;
        if (len >= 12'd2 && int'(len) <= MAX_PACKET_BYTES) begin
          s = int'(len) - 2;
          case (code)
            PROTO_NOTIFY:                  frame_ok = (s == 0);
            PROTO_INDEXED, PROTO_SEQ_RGBW: frame_ok = (s % 4 == 0);
            PROTO_SEQ_RGB:                 frame_ok = (s % 3 == 0);
            PROTO_OFFSET:                  frame_ok = (s >= 2) && ((s - 2) % 3 == 0);
            default:                       frame_ok = 1'b0;
          endcase
        end
        pix_index = '0;
        chan_phase = '0;
        staged = '0;
      end else if (byte_pos == 1) begin
        frame_timeout = value;
      end else if (frame_ok) begin
        p = int'(byte_pos) - 2;
        if (frame_proto == PROTO_OFFSET && p < 2) begin
          // Two big-endian bytes of start index precede the triples.
          if (p == 0) begin
            pix_index = {value, 8'h00};
          end else begin
            pix_index = pix_index | {8'h00, value};
          end
        end else begin
          group = (frame_proto == PROTO_INDEXED || frame_proto == PROTO_SEQ_RGBW) ? 4 : 3;
          if (int'(chan_phase) + 1 < group) begin
            staged = {staged[15:0], value};
            chan_phase = chan_phase + 2'd1;
          end else begin
            st = staged;
            chan_phase = '0;
            staged = '0;
            case (frame_proto)
              PROTO_INDEXED: begin
                write_pixel({8'h00, st[23:16]}, st[15:8], st[7:0], value, 8'h00);
              end
              PROTO_SEQ_RGBW: begin
                write_pixel(pix_index, st[23:16], st[15:8], st[7:0], value);
                pix_index = pix_index + 16'd1;
              end
              default: begin
                write_pixel(pix_index, st[15:8], st[7:0], value, 8'h00);
                pix_index = pix_index + 16'd1;
              end
            endcase
          end
        end
      end
      byte_pos++;
      if (byte_pos >= frame_len) begin
        add_result(frame_ok ? RES_SHOW : RES_REJECT, 16'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        if (frame_ok) begin
          if (frame_timeout == TIMEOUT_NEVER) begin
            blank_off = 1'b1;
          end else begin
            blank_off = 1'b0;
            countdown = (frame_timeout == 8'd0) ? DEFAULT_BLANK_MS
                                                : 18'(frame_timeout * 1000);
          end
        end
        byte_pos = 0;
      end
    end
    if (step_results.size() > 0) begin
      step_results[step_results.size() - 1].last = 1'b1;
    end
  endtask

  // Offers one item, in bursts with random gaps, and records what it causes.
  task automatic send_item(input bit kind, input logic [7:0] value, input logic [11:0] len,
                           input bit use_typed = 1'b0, input res_type_t typed_res = RES_PIXEL);
    int      gap;
    result_t typed_r;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (no_gaps || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {4'h0, len, value};
    s_axis_tuser <= kind;
    do @(posedge clk); while (!s_axis_tready);
    items_sent++;
    decode_item(kind, value, len);
    if (use_typed) begin
      typed_r = '0;
      typed_r.rtype = typed_res;
      typed_r.last = 1'b1;
      awaited_results.push_back(typed_r);
    end else begin
      foreach (step_results[i]) begin
        awaited_results.push_back(step_results[i]);
      end
    end
  endtask

  // Sends one packet. A negative length asks for a random one, mostly well formed.
  task automatic send_frame(input int len_req, input int proto_req);
    int          len;
    int          eff;
    int          sel;
    int          n;
    int          r;
    logic [7:0]  proto_b;
    logic [7:0]  tmo;
    logic [7:0]  v;
    logic [15:0] start;
    if (len_req >= 0) begin
      len = len_req;
      proto_b = 8'(proto_req);
    end else if ($urandom_range(0, 99) < 85) begin
      sel = $urandom_range(0, 4);
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(0, 6);
      case (sel)
        0:       len = 2 + (shadow_hyper ? 3 * n : 0);
        1, 3:    len = 2 + 4 * n;
        2:       len = 2 + 3 * n;
        default: len = 4 + 3 * n;
      endcase
      proto_b = 8'(sel);
    end else begin
      len = $urandom_range(0, 30);
      proto_b = ($urandom_range(0, 2) == 0) ? 8'($urandom) : 8'($urandom_range(0, 5));
    end
    r = $urandom_range(0, 15);
    if (r < 6) begin
      tmo = 8'd0;
    end else if (r < 10) begin
      tmo = 8'd1;
    end else if (r < 12) begin
      tmo = TIMEOUT_NEVER;
    end else if (r < 14) begin
      tmo = 8'($urandom_range(2, 4));
    end else begin
      tmo = 8'($urandom);
    end
    case ($urandom_range(0, 2))
      0:       start = 16'hFFFF - 16'($urandom_range(0, 3));
      1:       start = 16'($urandom_range(0, 40));
      default: start = 16'($urandom);
    endcase
    eff = (len == 0) ? 1 : len;
    for (int p = 0; p < eff; p++) begin
      if ($urandom_range(0, 11) == 0) begin
        send_item(KIND_TICK, 8'($urandom), 12'($urandom));
      end
      v = 8'($urandom);
      if (p == 0) begin
        v = proto_b;
      end else if (p == 1) begin
        v = tmo;
      end else if (proto_b == PROTO_OFFSET && p == 2) begin
        v = start[15:8];
      end else if (proto_b == PROTO_OFFSET && p == 3) begin
        v = start[7:0];
      end else if (proto_b == PROTO_INDEXED && (p - 2) % 4 == 0 && $urandom_range(0, 1) == 1) begin
        v = 8'($urandom_range(0, 63));
      end
      send_item(KIND_BYTE, v, (p == 0) ? 12'(len) : 12'($urandom));
    end
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) send_item(KIND_TICK, 8'($urandom), 12'($urandom));
    end
  endtask

  // Stops offering and waits until every awaited result has come out.
  task automatic settle();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_LED_COUNT) begin
      shadow_led_count = val;
    end else begin
      shadow_hyper = val[0];
    end
  endtask

  task automatic apply_config(input logic [15:0] leds, input logic hyper);
    settle();
    cfg_write(CFG_LED_COUNT, leds);
    cfg_write(CFG_SEQ_MODE, {15'd0, hyper});
  endtask

  // Receiver: its own stall pattern, plus long hold-offs on request.
  initial begin : receiver
    int mode;
    int rx_cycle;
    int hold_left;
    int holds_seen;
    mode = 0;
    rx_cycle = 0;
    hold_left = 0;
    holds_seen = 0;
    forever begin
      @(negedge clk);
      rx_cycle++;
      if (rx_cycle % 256 == 0) begin
        mode = $urandom_range(0, 3);
      end
      if (hold_requests != holds_seen) begin
        holds_seen = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        case (mode)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= ($urandom_range(0, 9) < 7);
          2:       m_axis_tready <= (rx_cycle % 5 < 3);
          default: m_axis_tready <= ($urandom_range(0, 9) < 3);
        endcase
      end
    end
  end

  always @(posedge clk) begin : result_check
    result_t got;
    result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.rtype = res_type_t'(m_axis_tuser);
      got.led_index = m_axis_tdata[15:0];
      got.red = m_axis_tdata[23:16];
      got.green = m_axis_tdata[31:24];
      got.blue = m_axis_tdata[39:32];
      got.white = m_axis_tdata[47:40];
      got.last = m_axis_tlast;
      if (awaited_results.size() == 0) begin
        note_failure($sformatf("result with nothing awaited: type %0d index %0d",
                               got.rtype, got.led_index));
      end else begin
        want = awaited_results.pop_front();
        if (got.rtype !== want.rtype)
          note_failure($sformatf("result_type got %0d, expected %0d", got.rtype, want.rtype));
        if (got.led_index !== want.led_index)
          note_failure($sformatf("led_index got %0d, expected %0d",
                                 got.led_index, want.led_index));
        if (got.red !== want.red)
          note_failure($sformatf("red got %02h, expected %02h", got.red, want.red));
        if (got.green !== want.green)
          note_failure($sformatf("green got %02h, expected %02h", got.green, want.green));
        if (got.blue !== want.blue)
          note_failure($sformatf("blue got %02h, expected %02h", got.blue, want.blue));
        if (got.white !== want.white)
          note_failure($sformatf("white got %02h, expected %02h", got.white, want.white));
        if (got.last !== want.last)
          note_failure($sformatf("last got %0b, expected %0b", got.last, want.last));
      end
    end
  end

  // Ends the run when neither side has moved a transfer for too long.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("** led_realtime_frame_parser: FAILED **");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int start_count;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      case (dir_rows[i].op)
        ROW_LED_COUNT: begin
          settle();
          cfg_write(CFG_LED_COUNT, dir_rows[i].cfg_val);
        end
        ROW_SEQ_MODE: begin
          settle();
          cfg_write(CFG_SEQ_MODE, dir_rows[i].cfg_val);
        end
        default: begin
          send_item((dir_rows[i].op == ROW_TICK) ? KIND_TICK : KIND_BYTE,
                    dir_rows[i].value, dir_rows[i].len, dir_rows[i].typed, dir_rows[i].want);
        end
      endcase
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0:       apply_config(16'hFFFF, 1'b0);
        1:       apply_config(16'($urandom_range(1, 48)), 1'b1);
        2:       apply_config(16'd0, 1'b0);
        3:       apply_config(16'($urandom), 1'b0);
        4:       apply_config(16'd1, 1'b1);
        default: apply_config(($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                          : 16'($urandom_range(1, 64)),
                              1'($urandom_range(0, 1)));
      endcase
      no_gaps = (ph == 1 || ph == 5);
      if (ph == 1) begin
        // The sender keeps offering while the receiver holds off.
        hold_requests++;
      end
      if (ph == 3) begin
        // An empty good frame with timeout 0, then enough ticks for one blank.
        send_item(KIND_BYTE, PROTO_NOTIFY, 12'd2);
        send_item(KIND_BYTE, 8'd0, 12'd0);
        repeat (1001) send_item(KIND_TICK, 8'($urandom), 12'($urandom));
      end
      start_count = items_sent;
      while (items_sent - start_count < ITEMS_PER_PHASE) begin
        send_frame(-1, -1);
      end
    end

    settle();
    if (fail_count == 0) begin
      $display("** led_realtime_frame_parser: PASSED **");
    end else begin
      $display("** led_realtime_frame_parser: FAILED **");
    end
    $finish;
  end

endmodule
